// ===== rtl/sfr_pkg.sv =====
// Shared constants and controller/datapath interface types for the sync frame receiver.
package sfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h06;
  localparam logic [7:0] SYNC_SECOND = 8'h85;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  localparam logic [5:0] SIZE_RESET = 6'd32;

  typedef struct packed {
    logic       start_body;
    logic       store;
    logic       emit_err;
    logic [1:0] err_code;
    logic       emit_start;
    logic       emit_rd;
    logic       emit_ld;
  } sfr_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_ok;
    logic room;
    logic csum_ok;
    logic cnt_zero;
    logic emit_last;
    logic out_free;
  } sfr_sts_t;

endpackage

// ===== rtl/sfr_datapath.sv =====
// Datapath: size register, byte counter, checksum, payload memory and result register.
module sfr_datapath import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_payload_size,
  input  logic [7:0] rx_byte,
  input  logic       out_stall,
  input  sfr_cmd_t   cmd,
  output sfr_sts_t   sts,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last_of_run
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] MAX_V = 7'(MAX_PAYLOAD);

  logic [5:0]       size_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  logic [7:0]       csum_r;
  logic [7:0]       rdata_r;
  logic [7:0]       mem [MAX_PAYLOAD];

  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [7:0]       data_r;
  logic [4:0]       index_r;
  logic             last_r;

  logic [6:0]       cnt_ext;
  logic [6:0]       size_ext;
  logic             size_ok;
  logic [CNT_W:0]   idx_inc;
  logic [CNT_W+4:0] idx_wide;
  logic             emit_last;

  assign cnt_ext   = 7'(cnt_r);
  assign size_ext  = {1'b0, size_r};
  assign size_ok   = (size_r != 6'd0) && (size_ext <= MAX_V);
  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign idx_wide  = {5'd0, idx_r};
  assign emit_last = (idx_inc == {1'b0, cnt_r});

  always_comb begin
    sts.is_sync1  = (rx_byte == SYNC_FIRST);
    sts.is_sync2  = (rx_byte == SYNC_SECOND);
    sts.len_ok    = size_ok && (rx_byte == {2'b00, size_r});
    sts.room      = (cnt_ext < size_ext) && (cnt_ext < MAX_V);
    sts.csum_ok   = (csum_r == rx_byte);
    sts.cnt_zero  = (cnt_r == '0);
    sts.emit_last = emit_last;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      cnt_r       <= '0;
      csum_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_payload_size;
      end
      if (cmd.start_body) begin
        cnt_r  <= '0;
        csum_r <= {2'b00, size_r};
      end else if (cmd.store) begin
        cnt_r  <= cnt_r + 1'b1;
        csum_r <= csum_r ^ rx_byte;
      end
      if (cmd.emit_err || cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.emit_rd) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
    if (cmd.emit_start) begin
      idx_r <= '0;
    end else if (cmd.emit_ld) begin
      idx_r <= idx_inc[CNT_W-1:0];
    end
    if (cmd.emit_err) begin
      status_r <= cmd.err_code;
      data_r   <= 8'd0;
      index_r  <= 5'd0;
      last_r   <= 1'b1;
    end else if (cmd.emit_ld) begin
      status_r <= ST_GOOD;
      data_r   <= rdata_r;
      index_r  <= idx_wide[4:0];
      last_r   <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_byte   = data_r;
  assign out_byte_index  = index_r;
  assign out_last_of_run = last_r;

endmodule

// ===== rtl/sfr_ctrl.sv =====
// Controller: frame parsing state machine and payload emission sequencing.
module sfr_ctrl import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sfr_sts_t sts,
  output sfr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_SYNC2,
    S_LEN,
    S_BODY,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   parsing;
  logic   accept;

  assign parsing  = (state_r == S_HUNT) || (state_r == S_SYNC2) ||
                    (state_r == S_LEN) || (state_r == S_BODY);
  assign in_stall = !parsing || !sts.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_HUNT: begin
        if (accept && sts.is_sync1) begin
          state_nxt = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (accept) begin
          if (sts.is_sync2) begin
            state_nxt = S_LEN;
          end else if (!sts.is_sync1) begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_LEN: begin
        if (accept) begin
          if (sts.len_ok) begin
            cmd.start_body = 1'b1;
            state_nxt      = S_BODY;
          end else begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ST_LEN;
            state_nxt    = S_HUNT;
          end
        end
      end
      S_BODY: begin
        if (accept) begin
          if (sts.room) begin
            cmd.store = 1'b1;
          end else if (!sts.csum_ok) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = ST_CSUM;
            state_nxt    = S_HUNT;
          end else if (sts.cnt_zero) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.emit_start = 1'b1;
            state_nxt      = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? S_HUNT : S_EMIT_RD;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sync_frame_receiver_xor.sv =====
// Top level of the sync-framed byte receiver with XOR checksum.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_rx_byte
//   out_    | output    | out_valid/out_stall| status, data_byte, byte_index, last_of_run
//   cfg_    | input     | cfg_wr_en          | cfg_payload_size
//
// Header and payload bytes are taken one per cycle while the result register is free.
// A good frame of N bytes is emitted as N results, as the payload memory is read once
// per result with a registered read port; input is stalled during that burst.
// Reset is synchronous and active low; it restores a payload size of 32 and the hunt.
// A stalled result in the result register stalls the input, whatever the next item is.
module sync_frame_receiver_xor import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_payload_size,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last_of_run
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_payload_size (cfg_payload_size),
    .rx_byte          (in_rx_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== rtl/sfr_chk.sv =====
// Port-level checker for the sync frame receiver and its bind to the top level.
module sfr_chk import sfr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_data_byte,
  input logic [4:0] out_byte_index,
  input logic       out_last_of_run
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_data_byte) && $stable(out_byte_index) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GOOD) |->
    out_last_of_run && (out_data_byte == 8'd0) && (out_byte_index == 5'd0))
    else $error("error result malformed");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_GOOD) && !out_last_of_run |-> in_stall)
    else $error("input taken during payload run");

endmodule

bind sync_frame_receiver_xor sfr_chk u_sfr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_data_byte   (out_data_byte),
  .out_byte_index  (out_byte_index),
  .out_last_of_run (out_last_of_run)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the sync-framed byte receiver with XOR checksum.
`timescale 1ns / 100ps

module tb import sfr_pkg::*; ();

  localparam int MAX_PAYLOAD = 32;
  localparam int DRAIN_CYCLES = 2 * MAX_PAYLOAD + 8;

  typedef enum logic [1:0] {PH_HUNT, PH_SYNC2, PH_LEN, PH_BODY} rx_phase_t;
  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_LEN, FR_NOISE, FR_CUT} frame_kind_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last_of_run;
  } frame_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_payload_size = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_data_byte;
  logic [4:0] out_byte_index;
  logic       out_last_of_run;

  rx_phase_t     rx_phase = PH_HUNT;
  logic [5:0]    frame_size = SIZE_RESET;
  int            stored = 0;
  logic [7:0]    fold = '0;
  logic [7:0]    body [MAX_PAYLOAD];
  frame_result_t frame_results_due [$];

  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned size_writes = 0;
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  int unsigned calm_left = 0;
  int unsigned hold_left = 0;

  sync_frame_receiver_xor #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_payload_size (cfg_payload_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm = ($urandom_range(0, 4) == 0);
      calm_left = $urandom_range(30, 120);
    end
    calm_left--;
    if (hold_left == 0 && !calm && $urandom_range(0, 2) == 0) begin
      hold_left = idle_length();
    end
    out_stall <= (hold_left != 0);
    if (hold_left != 0) begin
      hold_left--;
    end
  end

  function automatic void push_result(input logic [1:0] st, input logic [7:0] d,
                                      input logic [4:0] idx, input logic last);
    frame_result_t r;
    r.status = st;
    r.data_byte = d;
    r.byte_index = idx;
    r.last_of_run = last;
    frame_results_due.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (rx_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) rx_phase = PH_LEN;
        else if (b != SYNC_FIRST) rx_phase = PH_HUNT;
      end
      PH_LEN: begin
        if (frame_size >= 1 && frame_size <= MAX_PAYLOAD && b == {2'b00, frame_size}) begin
          rx_phase = PH_BODY;
          stored = 0;
          fold = {2'b00, frame_size};
        end else begin
          push_result(ST_LEN, 8'h00, 5'd0, 1'b1);
          rx_phase = PH_HUNT;
        end
      end
      default: begin
        if (stored < frame_size && stored < MAX_PAYLOAD) begin
          body[stored] = b;
          fold = fold ^ b;
          stored++;
        end else begin
          if (fold == b) begin
            for (int i = 0; i < stored && i < MAX_PAYLOAD; i++) begin
              push_result(ST_GOOD, body[i], 5'(i), (i + 1 == stored));
            end
          end else begin
            push_result(ST_CSUM, 8'h00, 5'd0, 1'b1);
          end
          rx_phase = PH_HUNT;
          stored = 0;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_result
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (frame_results_due.size() == 0) begin
        $error("unexpected result: status %0d data %0h index %0d last %0b",
               out_status, out_data_byte, out_byte_index, out_last_of_run);
        mismatches++;
      end else begin
        want = frame_results_due.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte mismatch: expected %0h, got %0h", want.data_byte, out_data_byte);
          mismatches++;
        end
        if (out_byte_index !== want.byte_index) begin
          $error("byte_index mismatch: expected %0d, got %0d", want.byte_index,
                 out_byte_index);
          mismatches++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $error("last_of_run mismatch: expected %0b, got %0b", want.last_of_run,
                 out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [5:0] v);
    wait_idle();
    cfg_payload_size = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    frame_size = v;
    size_writes++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] sum;
    logic [7:0] pick;
    int         count;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) send_byte(SYNC_FIRST);
    end
    send_byte(SYNC_FIRST);
    if (kind == FR_CUT && $urandom_range(0, 1) == 0) begin
      pick = 8'($urandom_range(0, 255));
      while (pick == SYNC_FIRST || pick == SYNC_SECOND) pick = 8'($urandom_range(0, 255));
      send_byte(pick);
      return;
    end
    send_byte(SYNC_SECOND);
    if (kind == FR_BAD_LEN) begin
      send_byte({2'b00, frame_size} + 8'($urandom_range(1, 255)));
      return;
    end
    send_byte({2'b00, frame_size});
    sum = {2'b00, frame_size};
    count = (kind == FR_CUT) ? $urandom_range(0, frame_size - 1) : frame_size;
    repeat (count) begin
      pick = 8'($urandom_range(0, 255));
      sum = sum ^ pick;
      send_byte(pick);
    end
    if (kind == FR_CUT) return;
    send_byte(kind == FR_BAD_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return FR_GOOD;
    if (r < 80) return FR_BAD_SUM;
    if (r < 88) return FR_BAD_LEN;
    if (r < 94) return FR_NOISE;
    return FR_CUT;
  endfunction

  task automatic test_sync_hunt();
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h41);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h05);
  endtask

  task automatic test_good_frame();
    set_size(6'd1);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFE);
  endtask

  task automatic test_bad_checksum();
    set_size(6'd2);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h00);
  endtask

  task automatic test_size_out_of_range();
    set_size(6'd0);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    set_size(6'd63);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h3F);
  endtask

  task automatic test_size_change_mid_frame();
    set_size(6'd4);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h04);
    send_byte(8'hAA);
    send_byte(8'h55);
    set_size(6'd2);
    send_byte(8'hFB);
    set_size(6'd3);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h03);
    set_size(6'd0);
    send_byte(8'h03);
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    for (int p = 0; p < 3; p++) begin
      set_size(6'($urandom_range(1, 8)));
      goal = bytes_sent + 18;
      while (bytes_sent < goal) send_frame(pick_kind());
    end
    set_size(6'd32);
    send_frame(FR_GOOD);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_sync_hunt();
    test_good_frame();
    test_bad_checksum();
    test_size_out_of_range();
    test_size_change_mid_frame();
    test_random_frames();
    wait_idle();
    $display("Sent %0d received bytes and checked %0d results across %0d size settings,",
             bytes_sent, results_seen, size_writes);
    $display("covering good frames, bad checksums, bad lengths, noise and cut frames.");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
